FILE: rtl/tmtw_pkg.sv
// Shared constants for the text-mode terminal writer: field widths, codes and defaults.
package tmtw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int MODE_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int COLOR_W   = 8;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int CELL_W    = 16;

   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

   localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

endpackage

FILE: rtl/tmtw_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module tmtw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/text_mode_terminal_writer_core.sv
// Text-mode terminal writer: screen memory, cursor control and the transaction handshakes.
//
// The screen of ROWS x COLUMNS cells (attribute byte above character byte) lives in one
// synchronous RAM with one write and one read port. After reset the block sweeps all
// ROWS*COLUMNS cells (2000 at 80x25) with blank grey cells and holds req_stall high
// meanwhile; csr writes are taken throughout. One transaction is worked on at a time and its
// result goes into an output register, so the next request is taken while a result still
// waits on rsp_stall. An ordinary character, backspace, newline without scroll or an unused
// mode goes from accept straight to the result state; a cell read first passes a read state
// for the registered RAM read. A newline on the last row, or a character that wraps off the
// last row, scrolls the screen through the RAM port pair (accept, copy, drain, blank fill,
// result). A clear runs accept, one RAM write per cell, then result.
module text_mode_terminal_writer_core
   import tmtw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [ROW_OUT_W-1:0] req_read_row,
   input  logic [COL_OUT_W-1:0] req_read_col,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ROW_OUT_W-1:0] rsp_cursor_row,
   output logic [COL_OUT_W-1:0] rsp_cursor_col,
   output logic [CELL_W-1:0]    rsp_cell_value,
   input  logic                 csr_wr_en,
   input  logic [COLOR_W-1:0]   csr_wr_data
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS);

   localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_STRIDE    = ADDR_W'(COLUMNS);
   localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_SCROLL,
      S_DRAIN,
      S_FILL,
      S_RESULT
   } state_type;

   state_type state_ff, state_in;

   logic [ROW_W-1:0]     cur_row_ff, cur_row_in;
   logic [COL_W-1:0]     cur_col_ff, cur_col_in;
   logic [ADDR_W-1:0]    cur_addr_ff, cur_addr_in;
   logic [ADDR_W-1:0]    sweep_ff, sweep_in;
   logic [ADDR_W-1:0]    dst_ff, dst_in;
   logic                 copy_pend_ff, copy_pend_in;
   logic [CELL_W-1:0]    fill_value_ff, fill_value_in;
   logic [CELL_W-1:0]    cell_ff, cell_in;
   logic                 read_ok_ff, read_ok_in;
   logic [COLOR_W-1:0]   text_color_ff, text_color_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ROW_OUT_W-1:0] rsp_cursor_row_ff, rsp_cursor_row_in;
   logic [COL_OUT_W-1:0] rsp_cursor_col_ff, rsp_cursor_col_in;
   logic [CELL_W-1:0]    rsp_cell_value_ff, rsp_cell_value_in;

   logic                 req_accept;
   logic                 do_newline;
   logic [CELL_W-1:0]    blank_cell;

   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [CELL_W-1:0]    mem_wr_data;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic [CELL_W-1:0]    mem_rd_data;

   tmtw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign blank_cell = {text_color_ff, CH_BLANK};

   always_comb begin
      state_in          = state_ff;
      cur_row_in        = cur_row_ff;
      cur_col_in        = cur_col_ff;
      cur_addr_in       = cur_addr_ff;
      sweep_in          = sweep_ff;
      dst_in            = dst_ff;
      copy_pend_in      = 1'b0;
      fill_value_in     = fill_value_ff;
      cell_in           = cell_ff;
      read_ok_in        = read_ok_ff;
      text_color_in     = csr_wr_en ? csr_wr_data : text_color_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_cursor_row_in = rsp_cursor_row_ff;
      rsp_cursor_col_in = rsp_cursor_col_ff;
      rsp_cell_value_in = rsp_cell_value_ff;
      do_newline        = 1'b0;
      mem_wr_en         = 1'b0;
      mem_wr_addr       = dst_ff;
      mem_wr_data       = mem_rd_data;
      mem_rd_addr       = sweep_ff;

      unique case (state_ff)
         S_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            mem_wr_data = fill_value_ff;
            if (sweep_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               cell_in  = '0;
               state_in = S_RESULT;
               unique case (req_mode)
                  MODE_WRITE: begin
                     if (req_char_code == CH_NEWLINE) begin
                        do_newline = 1'b1;
                     end else if (req_char_code == CH_BACKSPACE) begin
                        // At the home position a backspace leaves everything alone.
                        if (cur_col_ff != '0 || cur_row_ff != '0) begin
                           mem_wr_en   = 1'b1;
                           mem_wr_addr = cur_addr_ff - 1'b1;
                           mem_wr_data = blank_cell;
                           cur_addr_in = cur_addr_ff - 1'b1;
                           if (cur_col_ff == '0) begin
                              cur_row_in = cur_row_ff - 1'b1;
                              cur_col_in = LAST_COL;
                           end else begin
                              cur_col_in = cur_col_ff - 1'b1;
                           end
                        end
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = cur_addr_ff;
                        mem_wr_data = {text_color_ff, req_char_code};
                        if (cur_col_ff == LAST_COL) begin
                           do_newline = 1'b1;
                        end else begin
                           cur_col_in  = cur_col_ff + 1'b1;
                           cur_addr_in = cur_addr_ff + 1'b1;
                        end
                     end
                     if (do_newline) begin
                        cur_col_in = '0;
                        if (cur_row_ff == LAST_ROW) begin
                           cur_addr_in   = LAST_ROW_BASE;
                           sweep_in      = ROW_STRIDE;
                           fill_value_in = blank_cell;
                           state_in      = S_SCROLL;
                        end else begin
                           cur_row_in  = cur_row_ff + 1'b1;
                           cur_addr_in = cur_addr_ff - ADDR_W'(cur_col_ff) + ROW_STRIDE;
                        end
                     end
                  end
                  MODE_READ: begin
                     mem_rd_addr = ADDR_W'(32'(req_read_row) * COLUMNS + 32'(req_read_col));
                     read_ok_in  = (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLUMNS);
                     state_in    = S_READ;
                  end
                  MODE_CLEAR: begin
                     cur_row_in    = '0;
                     cur_col_in    = '0;
                     cur_addr_in   = '0;
                     sweep_in      = '0;
                     fill_value_in = blank_cell;
                     state_in      = S_FILL;
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_READ: begin
            cell_in  = read_ok_ff ? mem_rd_data : '0;
            state_in = S_RESULT;
         end
         S_SCROLL: begin
            // Each cell read here is written one row up in the following cycle.
            mem_wr_en    = copy_pend_ff;
            mem_rd_addr  = sweep_ff;
            copy_pend_in = 1'b1;
            dst_in       = sweep_ff - ROW_STRIDE;
            if (sweep_ff == LAST_ADDR) begin
               state_in = S_DRAIN;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            mem_wr_en = 1'b1;
            sweep_in  = LAST_ROW_BASE;
            state_in  = S_FILL;
         end
         S_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            mem_wr_data = fill_value_ff;
            if (sweep_ff == LAST_ADDR) begin
               state_in = S_RESULT;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_cursor_row_in = ROW_OUT_W'(cur_row_ff);
               rsp_cursor_col_in = COL_OUT_W'(cur_col_ff);
               rsp_cell_value_in = cell_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         cur_addr_ff   <= '0;
         sweep_ff      <= '0;
         copy_pend_ff  <= 1'b0;
         fill_value_ff <= {RESET_COLOR, CH_BLANK};
         text_color_ff <= RESET_COLOR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         cur_addr_ff   <= cur_addr_in;
         sweep_ff      <= sweep_in;
         copy_pend_ff  <= copy_pend_in;
         fill_value_ff <= fill_value_in;
         text_color_ff <= text_color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      dst_ff            <= dst_in;
      cell_ff           <= cell_in;
      read_ok_ff        <= read_ok_in;
      rsp_cursor_row_ff <= rsp_cursor_row_in;
      rsp_cursor_col_ff <= rsp_cursor_col_in;
      rsp_cell_value_ff <= rsp_cell_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_cursor_row_ff;
   assign rsp_cursor_col = rsp_cursor_col_ff;
   assign rsp_cell_value = rsp_cell_value_ff;

   // The linear cursor address must always agree with the row and column.
   assert property (@(posedge clock) disable iff (reset)
      (32'(cur_addr_ff) == 32'(cur_row_ff) * COLUMNS + 32'(cur_col_ff))
      && (32'(cur_row_ff) < ROWS) && (32'(cur_col_ff) < COLUMNS))
      else $error("cursor address out of step with row and column");

   assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (32'(mem_wr_addr) < CELLS))
      else $error("screen write beyond the last cell");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT))
      else $error("result raised outside the result state");

   assert property (@(posedge clock) disable iff (reset)
      copy_pend_ff |-> (32'(dst_ff) + COLUMNS == 32'($past(sweep_ff))))
      else $error("scroll copy written to the wrong row");

endmodule
